FILE: sv/lfh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Letter frequency histogram package
// Shared widths, codes, state type and the letter decoder.
// ----------------------------------------------------------------------------
package lfh_pkg;

  localparam int unsigned NumLetters     = 26;
  localparam int unsigned LetterWidth    = 5;
  localparam int unsigned ByteWidth      = 8;
  localparam int unsigned FracOutWidth   = 17;
  localparam int unsigned DefCountWidth  = 32;
  localparam int unsigned DefFracBits    = 16;

  localparam logic [ByteWidth-1:0] UpperFirst = 8'd65;
  localparam logic [ByteWidth-1:0] UpperLast  = 8'd90;
  localparam logic [ByteWidth-1:0] LowerFirst = 8'd97;
  localparam logic [ByteWidth-1:0] LowerLast  = 8'd122;

  localparam logic [LetterWidth-1:0] LastLetter = LetterWidth'(NumLetters - 1);

  typedef enum logic {
    ACT_COUNT  = 1'b0,
    ACT_FINISH = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic                   hit;
    logic [LetterWidth-1:0] idx;
  } letter_t;

  // Fold a byte onto its letter bin; hit is low for anything not a letter.
  function automatic letter_t letter_decode(input logic [ByteWidth-1:0] b);
    letter_t              res;
    logic [ByteWidth-1:0] diff;
    res  = '0;
    diff = '0;
    if (b >= UpperFirst && b <= UpperLast) begin
      diff    = b - UpperFirst;
      res.hit = 1'b1;
    end else if (b >= LowerFirst && b <= LowerLast) begin
      diff    = b - LowerFirst;
      res.hit = 1'b1;
    end
    res.idx = diff[LetterWidth-1:0];
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: sv/lfh_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Letter frequency histogram input channel
// Valid/ready channel carrying one text byte or a finish request per beat.
// ----------------------------------------------------------------------------
interface lfh_in_if;
  logic                          valid;
  logic                          ready;
  lfh_pkg::action_e              action;
  logic [lfh_pkg::ByteWidth-1:0] byte_value;

  modport source (output valid, output action, output byte_value, input ready);
  modport sink   (input valid, input action, input byte_value, output ready);
endinterface
`default_nettype wire

FILE: sv/lfh_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Letter frequency histogram output channel
// Valid/ready channel carrying one letter's frequency per beat.
// ----------------------------------------------------------------------------
interface lfh_out_if;
  logic                             valid;
  logic                             ready;
  logic [lfh_pkg::LetterWidth-1:0]  letter_index;
  logic [lfh_pkg::FracOutWidth-1:0] fraction;
  logic                             no_letters;
  logic                             last_bin;

  modport source (output valid, output letter_index, output fraction,
                  output no_letters, output last_bin, input ready);
  modport sink   (input valid, input letter_index, input fraction,
                  input no_letters, input last_bin, output ready);
endinterface
`default_nettype wire

FILE: sv/letter_frequency_histogram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Letter frequency histogram
// Counts ASCII letters into 26 bins and reports each bin as a Q1.16 share.
// ----------------------------------------------------------------------------
// Count beats (action = count) are taken one per cycle whenever the block is
// idle: a letter of either case bumps its bin and the letter total, both
// saturating at all ones, and any other byte is dropped. A finish beat
// closes the run and produces 26 result beats in letter order, the last one
// flagged by last_bin. Each fraction is floor(bin * 2^FRACTION_BITS / total)
// from a bit-serial restoring divider that retires one quotient bit per
// cycle. For each letter the block pulls the next bin off the front of the
// bin shift line, runs FRACTION_BITS + 1 divide steps and hands the result
// to the output register, waiting out any stall from the sink; no input
// is taken until the whole finish is done. When no letter was counted,
// every fraction reads zero and no_letters is high. The bins and total
// are empty again as soon as the finish completes; the next run may
// start while the last result still waits in the output register.
// ----------------------------------------------------------------------------
module letter_frequency_histogram #(
  parameter int unsigned COUNT_WIDTH   = lfh_pkg::DefCountWidth,
  parameter int unsigned FRACTION_BITS = lfh_pkg::DefFracBits
) (
  input  wire    clk_i,
  input  wire    rst_ni,
  lfh_in_if.sink    in_i,
  lfh_out_if.source out_o
);
  import lfh_pkg::*;

  localparam int unsigned StepWidth = $clog2(FRACTION_BITS + 1);

  // Bin shift line: bins are counted in place and drained from the front.
  logic [COUNT_WIDTH-1:0] bins_q [NumLetters];
  logic [COUNT_WIDTH-1:0] bins_d [NumLetters];
  logic [COUNT_WIDTH-1:0] total_q, total_d;

  // Divider registers.
  logic [COUNT_WIDTH-1:0] den_q;
  logic [COUNT_WIDTH:0]   rem_q, rem_d;
  logic [FRACTION_BITS:0] quo_q, quo_d;
  logic [StepWidth-1:0]   step_q;
  logic                   empty_q;
  logic [LetterWidth-1:0] letter_q;

  // Output register.
  logic                    out_valid_q;
  logic [LetterWidth-1:0]  out_index_q;
  logic [FracOutWidth-1:0] out_frac_q;
  logic                    out_empty_q;
  logic                    out_last_q;

  state_e state_q, state_d;

  letter_t dec;
  logic    in_beat, count_beat, finish_beat, out_free, trial_ge;
  logic [COUNT_WIDTH:0] trial;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_beat     = in_i.valid && in_i.ready;
  assign count_beat  = in_beat && (in_i.action == ACT_COUNT);
  assign finish_beat = in_beat && (in_i.action == ACT_FINISH);
  assign dec         = letter_decode(in_i.byte_value);
  assign out_free    = !out_valid_q || out_o.ready;

  // One restoring step: the first step tests the bare bin for the integer
  // bit, later steps double the remainder first.
  assign trial    = (step_q == '0) ? rem_q : {rem_q[COUNT_WIDTH-1:0], 1'b0};
  assign trial_ge = (trial >= {1'b0, den_q});

  always_comb begin
    rem_d = trial_ge ? (trial - {1'b0, den_q}) : trial;
    quo_d = {quo_q[FRACTION_BITS-1:0], trial_ge};
  end

  // Bin and total update: increment on a letter, shift toward the front while
  // draining, clear the total on finish.
  always_comb begin
    for (int k = 0; k < NumLetters; k++) begin
      bins_d[k] = bins_q[k];
      if (state_q == ST_LOAD) begin
        bins_d[k] = (k == NumLetters - 1) ? '0 : bins_q[(k + 1) % NumLetters];
      end else if (count_beat && dec.hit && (dec.idx == LetterWidth'(k))) begin
        bins_d[k] = (&bins_q[k]) ? bins_q[k] : bins_q[k] + 1'b1;
      end
    end
    total_d = total_q;
    if (finish_beat) begin
      total_d = '0;
    end else if (count_beat && dec.hit && !(&total_q)) begin
      total_d = total_q + 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (finish_beat) state_d = ST_LOAD;
      ST_LOAD: state_d = ST_DIV;
      ST_DIV:  if (step_q == StepWidth'(FRACTION_BITS)) state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_d = (letter_q == LastLetter) ? ST_IDLE : ST_LOAD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      letter_q    <= '0;
      step_q      <= '0;
      for (int k = 0; k < NumLetters; k++) begin
        bins_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      bins_q  <= bins_d;
      if (finish_beat) begin
        letter_q <= '0;
      end else if (state_q == ST_EMIT && out_free && letter_q != LastLetter) begin
        letter_q <= letter_q + 1'b1;
      end
      if (state_q == ST_LOAD) begin
        step_q <= '0;
      end else if (state_q == ST_DIV) begin
        step_q <= step_q + 1'b1;
      end
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (finish_beat) begin
      den_q   <= total_q;
      empty_q <= (total_q == '0);
    end
    if (state_q == ST_LOAD) begin
      rem_q <= {1'b0, bins_q[0]};
      quo_q <= '0;
    end else if (state_q == ST_DIV) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (state_q == ST_EMIT && out_free) begin
      out_index_q <= letter_q;
      out_frac_q  <= empty_q ? '0 : FracOutWidth'(quo_q);
      out_empty_q <= empty_q;
      out_last_q  <= (letter_q == LastLetter);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.letter_index = out_index_q;
  assign out_o.fraction     = out_frac_q;
  assign out_o.no_letters   = out_empty_q;
  assign out_o.last_bin     = out_last_q;

endmodule
`default_nettype wire
